@@ sv/open_addressing_hash_table_core_assert.svh @@
// Assertion macros for the hash table RTL, used in oaht_ctrl.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef OPEN_ADDRESSING_HASH_TABLE_CORE_ASSERT_SVH
`define OPEN_ADDRESSING_HASH_TABLE_CORE_ASSERT_SVH

// same-cycle implication
`define OAHT_ASSERT_IMM(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OAHT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/oaht_pkg.sv @@
// Shared types and codes for the open-addressing hash table.
// No dependencies.
package oaht_pkg;

  localparam int SLOTS_DEFAULT = 256;

  localparam logic [1:0] REQ_SET    = 2'd0;
  localparam logic [1:0] REQ_GET    = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  localparam logic [1:0] TAG_EMPTY = 2'd0;
  localparam logic [1:0] TAG_LIVE  = 2'd1;
  localparam logic [1:0] TAG_TOMB  = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [7:0] MAX_FILL_RST = 8'd192;
  localparam logic [8:0] COUNT_MAX    = 9'd511;

  typedef struct packed {
    logic tag_we;
    logic key_we;
    logic val_we;
  } mem_we_t;

  typedef struct packed {
    logic [1:0]  tag;
    logic [31:0] key;
    logic [63:0] val;
  } slot_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        is_new_key;
    logic [63:0] value_out;
  } rsp_t;

endpackage

@@ sv/oaht_if.sv @@
// Valid/ready channel interfaces for hash table requests and responses.
// No dependencies.
interface oaht_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] key_id;
  logic [31:0] key_hash;
  logic [63:0] value_in;

  modport source (output valid, req_type, key_id, key_hash, value_in, input ready);
  modport sink   (input valid, req_type, key_id, key_hash, value_in, output ready);
endinterface

interface oaht_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        is_new_key;
  logic [63:0] value_out;

  modport source (output valid, status, is_new_key, value_out, input ready);
  modport sink   (input valid, status, is_new_key, value_out, output ready);
endinterface

@@ sv/oaht_hash_mod.sv @@
// Start slot unit: key_hash mod SLOTS.
// Mask for power-of-two SLOTS, else reciprocal multiply and subtract in states P_LO, P_HI, P_REM.
module oaht_hash_mod #(
  parameter int SLOTS = 256,
  parameter int IDXW  = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [31:0]     hash,
  output logic            done,
  output logic [IDXW-1:0] idx
);
  localparam bit POW2 = ((SLOTS & (SLOTS - 1)) == 0);

  generate
    if (POW2) begin : g_mask
      logic            done_r;
      logic [IDXW-1:0] idx_r;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          done_r <= 1'b0;
        end else begin
          done_r <= start;
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          idx_r <= hash[IDXW-1:0];
        end
      end

      assign done = done_r;
      assign idx  = idx_r;
    end else begin : g_recip
      localparam logic [63:0] RECIP_W =
        ((64'd1 << (32 + IDXW)) + 64'(SLOTS - 1)) / 64'(SLOTS);
      localparam logic [32:0] RECIP   = RECIP_W[32:0];
      localparam logic [31:0] SLOTS_W = 32'(SLOTS);

      localparam logic [1:0] P_IDLE = 2'd0;
      localparam logic [1:0] P_LO   = 2'd1;
      localparam logic [1:0] P_HI   = 2'd2;
      localparam logic [1:0] P_REM  = 2'd3;

      logic [1:0]      phase_r, phase_nxt;
      logic            done_r, done_nxt;
      logic [31:0]     h_r, h_nxt;
      logic [48:0]     plo_r, plo_nxt;
      logic [31:0]     q_r, q_nxt;
      logic [IDXW-1:0] rem_r, rem_nxt;
      logic [48:0]     phi;
      logic [64:0]     acc;
      logic [31:0]     qd;

      always_comb begin
        phase_nxt = phase_r;
        done_nxt  = 1'b0;
        h_nxt     = h_r;
        plo_nxt   = plo_r;
        q_nxt     = q_r;
        rem_nxt   = rem_r;
        phi       = h_r[31:16] * RECIP;
        acc       = {phi, 16'd0} + {16'd0, plo_r};
        qd        = q_r * SLOTS_W;
        if (start) begin
          h_nxt     = hash;
          phase_nxt = P_LO;
        end else begin
          unique case (phase_r)
            P_LO: begin
              plo_nxt   = h_r[15:0] * RECIP;
              phase_nxt = P_HI;
            end
            P_HI: begin
              q_nxt     = 32'(acc >> (32 + IDXW));
              phase_nxt = P_REM;
            end
            P_REM: begin
              rem_nxt   = IDXW'(h_r - qd);
              done_nxt  = 1'b1;
              phase_nxt = P_IDLE;
            end
            default: begin
              phase_nxt = P_IDLE;
            end
          endcase
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          phase_r <= P_IDLE;
          done_r  <= 1'b0;
        end else begin
          phase_r <= phase_nxt;
          done_r  <= done_nxt;
        end
      end

      always_ff @(posedge clk) begin
        h_r   <= h_nxt;
        plo_r <= plo_nxt;
        q_r   <= q_nxt;
        rem_r <= rem_nxt;
      end

      assign done = done_r;
      assign idx  = rem_r;
    end
  endgenerate

endmodule

@@ sv/oaht_slot_mem.sv @@
// Slot store: tag, key and value memories, one write and one read port each.
// Depends on oaht_pkg. Read data is registered.
module oaht_slot_mem #(
  parameter int SLOTS = 256,
  parameter int IDXW  = 8
) (
  input  logic             clk,
  input  oaht_pkg::mem_we_t wr_en,
  input  logic [IDXW-1:0]  wr_addr,
  input  oaht_pkg::slot_t  wr_slot,
  input  logic [IDXW-1:0]  rd_addr,
  output oaht_pkg::slot_t  rd_slot
);
  import oaht_pkg::*;

  logic [1:0]  tag_mem [SLOTS];
  logic [31:0] key_mem [SLOTS];
  logic [63:0] val_mem [SLOTS];
  slot_t       rd_r;

  always_ff @(posedge clk) begin
    if (wr_en.tag_we) begin
      tag_mem[wr_addr] <= wr_slot.tag;
    end
    if (wr_en.key_we) begin
      key_mem[wr_addr] <= wr_slot.key;
    end
    if (wr_en.val_we) begin
      val_mem[wr_addr] <= wr_slot.val;
    end
    rd_r.tag <= tag_mem[rd_addr];
    rd_r.key <= key_mem[rd_addr];
    rd_r.val <= val_mem[rd_addr];
  end

  assign rd_slot = rd_r;

endmodule

@@ sv/oaht_ctrl.sv @@
// Probe sequencer: tag clear sweep, linear probe with one compare per cycle,
// commit, occupancy count and response register. Depends on oaht_pkg.
`include "open_addressing_hash_table_core_assert.svh"

module oaht_ctrl #(
  parameter int SLOTS = 256,
  parameter int IDXW  = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_req_type,
  input  logic [31:0]       in_key_id,
  input  logic [63:0]       in_value_in,
  output logic              hash_start,
  input  logic              hash_done,
  input  logic [IDXW-1:0]   hash_idx,
  output logic [IDXW-1:0]   rd_addr,
  input  oaht_pkg::slot_t   rd_slot,
  output oaht_pkg::mem_we_t wr_en,
  output logic [IDXW-1:0]   wr_addr,
  output oaht_pkg::slot_t   wr_slot,
  output logic              out_valid,
  input  logic              out_ready,
  output oaht_pkg::rsp_t    out_rsp
);
  import oaht_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_PROBE = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(SLOTS - 1);

  logic [2:0]      state_r, state_nxt;
  logic [IDXW-1:0] idx_r, idx_nxt;
  logic [IDXW-1:0] n_r, n_nxt;
  logic            tomb_seen_r, tomb_seen_nxt;
  logic [IDXW-1:0] tomb_idx_r, tomb_idx_nxt;
  logic [1:0]      req_r, req_nxt;
  logic [31:0]     key_r, key_nxt;
  logic [63:0]     val_r, val_nxt;
  rsp_t            res_r, res_nxt;
  logic [8:0]      count_r, count_nxt;
  logic [7:0]      max_fill_r, max_fill_nxt;
  logic            out_valid_r, out_valid_nxt;
  rsp_t            out_rsp_r, out_rsp_nxt;

  logic [IDXW-1:0] idx_inc;
  logic            hit, is_tomb, is_empty, last;
  logic            tomb_now, have_spot, fresh, full;
  logic [IDXW-1:0] tomb_idx_now, spot;

  always_comb begin
    idx_inc      = (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;
    hit          = (rd_slot.tag == TAG_LIVE) && (rd_slot.key == key_r);
    is_tomb      = (rd_slot.tag == TAG_TOMB);
    is_empty     = (rd_slot.tag != TAG_LIVE) && !is_tomb;
    last         = (n_r == LAST_IDX);
    tomb_now     = tomb_seen_r | is_tomb;
    tomb_idx_now = tomb_seen_r ? tomb_idx_r : idx_r;
    have_spot    = is_empty | tomb_now;
    spot         = tomb_now ? tomb_idx_now : idx_r;
    fresh        = !tomb_now;
    full         = (({1'b0, count_r} + 10'd1) >= {2'b00, max_fill_r}) || !have_spot;

    state_nxt     = state_r;
    idx_nxt       = idx_r;
    n_nxt         = n_r;
    tomb_seen_nxt = tomb_seen_r;
    tomb_idx_nxt  = tomb_idx_r;
    req_nxt       = req_r;
    key_nxt       = key_r;
    val_nxt       = val_r;
    res_nxt       = res_r;
    count_nxt     = count_r;
    max_fill_nxt  = cfg_we ? cfg_wdata : max_fill_r;
    out_valid_nxt = (out_valid_r && out_ready) ? 1'b0 : out_valid_r;
    out_rsp_nxt   = out_rsp_r;

    hash_start = 1'b0;
    rd_addr    = idx_inc;
    wr_en      = '0;
    wr_addr    = idx_r;
    wr_slot    = '{tag: TAG_LIVE, key: key_r, val: val_r};

    unique case (state_r)
      S_CLEAR: begin
        wr_en.tag_we = 1'b1;
        wr_slot.tag  = TAG_EMPTY;
        idx_nxt      = idx_inc;
        if (idx_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          req_nxt       = in_req_type;
          key_nxt       = in_key_id;
          val_nxt       = in_value_in;
          n_nxt         = '0;
          tomb_seen_nxt = 1'b0;
          res_nxt       = '{status: ST_MISS, is_new_key: 1'b0, value_out: '0};
          if (in_req_type == REQ_SET || in_req_type == REQ_GET ||
              in_req_type == REQ_REMOVE) begin
            hash_start = 1'b1;
            state_nxt  = S_HASH;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_HASH: begin
        rd_addr = hash_idx;
        if (hash_done) begin
          idx_nxt   = hash_idx;
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        idx_nxt       = idx_inc;
        n_nxt         = n_r + 1'b1;
        tomb_seen_nxt = tomb_now;
        tomb_idx_nxt  = tomb_idx_now;
        if (hit) begin
          state_nxt      = S_DONE;
          res_nxt.status = ST_OK;
          case (req_r)
            REQ_SET: begin
              wr_en.val_we = 1'b1;
            end
            REQ_GET: begin
              res_nxt.value_out = rd_slot.val;
            end
            default: begin
              wr_en.tag_we = 1'b1;
              wr_slot.tag  = TAG_TOMB;
            end
          endcase
        end else if (is_empty || last) begin
          state_nxt = S_DONE;
          if (req_r == REQ_SET) begin
            if (full) begin
              res_nxt.status = ST_FULL;
            end else begin
              res_nxt.status     = ST_OK;
              res_nxt.is_new_key = fresh;
              wr_en              = '{tag_we: 1'b1, key_we: 1'b1, val_we: 1'b1};
              wr_addr            = spot;
              if (fresh && count_r != COUNT_MAX) begin
                count_nxt = count_r + 9'd1;
              end
            end
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_rsp_nxt   = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      idx_r       <= '0;
      count_r     <= '0;
      max_fill_r  <= MAX_FILL_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      count_r     <= count_nxt;
      max_fill_r  <= max_fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    tomb_seen_r <= tomb_seen_nxt;
    tomb_idx_r  <= tomb_idx_nxt;
    req_r       <= req_nxt;
    key_r       <= key_nxt;
    val_r       <= val_nxt;
    res_r       <= res_nxt;
    out_rsp_r   <= out_rsp_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  `OAHT_ASSERT_IMM(a_wr_phase, wr_en.tag_we || wr_en.key_we || wr_en.val_we, state_r == S_CLEAR || state_r == S_PROBE, "slot write outside clear or probe")
  `OAHT_ASSERT_IMM(a_key_live, wr_en.key_we, wr_en.tag_we && wr_slot.tag == TAG_LIVE && wr_en.val_we, "key write without live tag")
  `OAHT_ASSERT_NXT(a_count_mono, $past(rst_n), count_r >= $past(count_r), "occupancy count decreased")
  `OAHT_ASSERT_NXT(a_rsp_push, state_r == S_DONE && (!out_valid_r || out_ready), out_valid_r && state_r == S_IDLE, "response not pushed")

endmodule

@@ sv/open_addressing_hash_table_core.sv @@
// Linear-probing hash table: start slot is key_hash mod SLOTS, masked for power-of-two
// SLOTS, else a reciprocal remainder; then one probe compare per cycle until a hit, an
// empty slot or all slots probed. One request at a time: in_req.ready is low until the
// response is registered. After reset the tag store is swept to empty, in_req.ready low.
// max_fill resets to 192, occupancy count to 0.
module open_addressing_hash_table_core #(
  parameter int SLOTS = oaht_pkg::SLOTS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  oaht_req_if.sink   in_req,
  oaht_rsp_if.source out_rsp
);
  import oaht_pkg::*;

  localparam int IDXW = $clog2(SLOTS);

  logic            hash_start, hash_done;
  logic [IDXW-1:0] hash_idx;
  logic [IDXW-1:0] rd_addr, wr_addr;
  slot_t           rd_slot, wr_slot;
  mem_we_t         wr_en;
  logic            in_ready, out_valid;
  rsp_t            rsp;

  oaht_hash_mod #(.SLOTS(SLOTS), .IDXW(IDXW)) u_hash_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hash_start),
    .hash  (in_req.key_hash),
    .done  (hash_done),
    .idx   (hash_idx)
  );

  oaht_slot_mem #(.SLOTS(SLOTS), .IDXW(IDXW)) u_slot_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_slot (wr_slot),
    .rd_addr (rd_addr),
    .rd_slot (rd_slot)
  );

  oaht_ctrl #(.SLOTS(SLOTS), .IDXW(IDXW)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_req.valid),
    .in_ready    (in_ready),
    .in_req_type (in_req.req_type),
    .in_key_id   (in_req.key_id),
    .in_value_in (in_req.value_in),
    .hash_start  (hash_start),
    .hash_done   (hash_done),
    .hash_idx    (hash_idx),
    .rd_addr     (rd_addr),
    .rd_slot     (rd_slot),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_slot     (wr_slot),
    .out_valid   (out_valid),
    .out_ready   (out_rsp.ready),
    .out_rsp     (rsp)
  );

  assign in_req.ready       = in_ready;
  assign out_rsp.valid      = out_valid;
  assign out_rsp.status     = rsp.status;
  assign out_rsp.is_new_key = rsp.is_new_key;
  assign out_rsp.value_out  = rsp.value_out;

endmodule

@@ tb/testbench.sv @@
// Self-checking bench for open_addressing_hash_table_core: set/get/remove requests in,
// responses checked against a behavioral table model kept in the bench.
// Depends on oaht_pkg and the oaht_req_if/oaht_rsp_if channel interfaces.
module testbench;
  import oaht_pkg::*;

  localparam int SLOTS = 256;
  localparam int CLK_PERIOD = 12;
  localparam longint TIMEOUT = 64'd2_500_000 * CLK_PERIOD;
  localparam int POOL_SIZE = 48;

  localparam logic [31:0] KEY_A = 32'h1234_5678;
  localparam logic [31:0] KEY_B = 32'h8765_4321;
  localparam logic [31:0] KEY_C = 32'hDEAD_BEEF;
  localparam logic [31:0] KEY_D = 32'h0F0F_A5A5;
  localparam logic [31:0] HASH_TOP = 32'hABCD_00FF;
  localparam logic [1:0]  REQ_UNUSED = 2'd3;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [7:0] cfg_wdata;

  oaht_req_if req_ch ();
  oaht_rsp_if rsp_ch ();

  open_addressing_hash_table_core #(.SLOTS(SLOTS)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_req   (req_ch),
    .out_rsp  (rsp_ch)
  );

  // table model
  logic [1:0]  tbl_tag [SLOTS];
  logic [31:0] tbl_key [SLOTS];
  logic [63:0] tbl_val [SLOTS];
  logic [8:0]  fill_count;
  logic [7:0]  fill_limit;

  rsp_t expected_rsp [$];
  int   error_count = 0;
  int   sender_idle_pct = 14;
  int   receiver_idle_pct = 61;
  int   hold_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(TIMEOUT);
    $display("TEST FAILED");
    $finish;
  end

  function automatic rsp_t table_apply(input logic [1:0] op, input logic [31:0] key,
                                       input logic [31:0] hash, input logic [63:0] val);
    rsp_t r;
    int idx, n, hit, tomb_idx, spot;
    bit found, tomb_seen, have_spot, fresh, stop;
    r.status = ST_MISS;
    r.is_new_key = 1'b0;
    r.value_out = '0;
    if (op != REQ_SET && op != REQ_GET && op != REQ_REMOVE) return r;
    idx = int'(hash % SLOTS);
    found = 0; tomb_seen = 0; have_spot = 0; fresh = 0; stop = 0;
    hit = 0; tomb_idx = 0; spot = 0;
    for (n = 0; n < SLOTS && !stop; n++) begin
      if (tbl_tag[idx] == TAG_LIVE) begin
        if (tbl_key[idx] == key) begin
          found = 1;
          hit = idx;
          stop = 1;
        end
      end else if (tbl_tag[idx] == TAG_TOMB) begin
        if (!tomb_seen) begin
          tomb_seen = 1;
          tomb_idx = idx;
        end
      end else begin
        have_spot = 1;
        stop = 1;
        if (tomb_seen) begin
          spot = tomb_idx;
        end else begin
          spot = idx;
          fresh = 1;
        end
      end
      idx = (idx + 1) % SLOTS;
    end
    if (!found && !have_spot && tomb_seen) begin
      have_spot = 1;
      spot = tomb_idx;
    end
    case (op)
      REQ_SET: begin
        if (found) begin
          tbl_val[hit] = val;
          r.status = ST_OK;
        end else if (int'(fill_count) + 1 >= int'(fill_limit) || !have_spot) begin
          r.status = ST_FULL;
        end else begin
          if (fresh) begin
            if (fill_count < COUNT_MAX) fill_count = fill_count + 9'd1;
            r.is_new_key = 1'b1;
          end
          tbl_tag[spot] = TAG_LIVE;
          tbl_key[spot] = key;
          tbl_val[spot] = val;
          r.status = ST_OK;
        end
      end
      REQ_GET: begin
        if (found) begin
          r.value_out = tbl_val[hit];
          r.status = ST_OK;
        end
      end
      default: begin
        if (found) begin
          tbl_tag[hit] = TAG_TOMB;
          r.status = ST_OK;
        end
      end
    endcase
    return r;
  endfunction

  task automatic send_request(input logic [1:0] op, input logic [31:0] key,
                              input logic [31:0] hash, input logic [63:0] val);
    while ($urandom_range(99) < sender_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= op;
    req_ch.key_id   <= key;
    req_ch.key_hash <= hash;
    req_ch.value_in <= val;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    expected_rsp.push_back(table_apply(op, key, hash, val));
  endtask

  task automatic wait_idle(input int extra);
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_max_fill(input logic [7:0] limit);
    cfg_we    <= 1'b1;
    cfg_wdata <= limit;
    @(posedge clk);
    cfg_we <= 1'b0;
    fill_limit = limit;
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand_value();
    return {$urandom(), $urandom()};
  endfunction

  // max_fill of 0 and 1 refuse every new key
  task automatic test_fill_limit_extremes();
    write_max_fill(8'd0);
    send_request(REQ_SET, KEY_A, HASH_TOP, rand_value());
    wait_idle(4);
    write_max_fill(8'd1);
    send_request(REQ_SET, KEY_A, HASH_TOP, rand_value());
    wait_idle(4);
    write_max_fill(8'd255);
  endtask

  // collisions at the top slot wrap to slot 0; overwrite and misses
  task automatic test_basic_ops();
    send_request(REQ_SET, KEY_A, HASH_TOP, '1);
    send_request(REQ_SET, KEY_B, HASH_TOP, rand_value());
    send_request(REQ_GET, KEY_A, HASH_TOP, rand_value());
    send_request(REQ_GET, KEY_B, HASH_TOP, '0);
    send_request(REQ_SET, KEY_A, HASH_TOP, '0);
    send_request(REQ_GET, KEY_A, HASH_TOP, '1);
    send_request(REQ_GET, KEY_C, HASH_TOP, rand_value());
    send_request(REQ_REMOVE, KEY_C, HASH_TOP, rand_value());
    send_request(REQ_SET, 32'h0000_0000, 32'h0000_0000, rand_value());
    send_request(REQ_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, rand_value());
    send_request(REQ_UNUSED, KEY_B, HASH_TOP, '1);
    send_request(REQ_GET, KEY_B, HASH_TOP, rand_value());
  endtask

  // remove leaves a tombstone that later probes pass and a set reuses
  task automatic test_tombstones();
    send_request(REQ_REMOVE, KEY_A, HASH_TOP, rand_value());
    send_request(REQ_GET, KEY_B, HASH_TOP, rand_value());
    send_request(REQ_GET, KEY_A, HASH_TOP, rand_value());
    send_request(REQ_SET, KEY_C, HASH_TOP, rand_value());
    send_request(REQ_GET, KEY_C, HASH_TOP, rand_value());
    wait_idle(4);
  endtask

  // at the limit: new keys refused, present keys still updated
  task automatic test_limit_present_keys();
    write_max_fill(fill_count[7:0] + 8'd1);
    send_request(REQ_SET, KEY_D, HASH_TOP, rand_value());
    send_request(REQ_SET, KEY_B, HASH_TOP, rand_value());
    send_request(REQ_REMOVE, KEY_B, HASH_TOP, rand_value());
    send_request(REQ_SET, KEY_D, HASH_TOP, rand_value());
    wait_idle(4);
    write_max_fill(fill_count[7:0] + 8'd2);
    send_request(REQ_SET, KEY_D, HASH_TOP, rand_value());
    send_request(REQ_GET, KEY_D, HASH_TOP, rand_value());
    wait_idle(4);
  endtask

  task automatic test_random_phase(input int n_items, input logic [7:0] limit,
                                   input int snd_idle, input int rcv_idle);
    logic [31:0] pool_key [POOL_SIZE];
    logic [31:0] pool_hash [POOL_SIZE];
    logic [7:0]  base;
    logic [31:0] h;
    int i, pick, sel;
    wait_idle(4);
    write_max_fill(limit);
    sender_idle_pct = snd_idle;
    receiver_idle_pct = rcv_idle;
    base = 8'($urandom());
    for (i = 0; i < POOL_SIZE; i++) begin
      pool_key[i] = $urandom();
      h = $urandom();
      h[7:0] = base + 8'($urandom_range(0, 15));
      pool_hash[i] = h;
    end
    for (i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      sel = $urandom_range(POOL_SIZE - 1);
      if (pick < 40)
        send_request(REQ_SET, pool_key[sel], pool_hash[sel], rand_value());
      else if (pick < 72)
        send_request(REQ_GET, pool_key[sel], pool_hash[sel], rand_value());
      else if (pick < 90)
        send_request(REQ_REMOVE, pool_key[sel], pool_hash[sel], rand_value());
      else if (pick < 95)
        send_request(REQ_SET, $urandom(), $urandom(), rand_value());
      else if (pick < 98)
        send_request(REQ_GET, $urandom(), $urandom(), rand_value());
      else
        send_request(REQ_UNUSED, pool_key[sel], pool_hash[sel], rand_value());
    end
  endtask

  // receiver holds off long enough for the core to stall its request side
  task automatic test_backpressure();
    int i;
    wait_idle(4);
    sender_idle_pct = 0;
    hold_cycles = 300;
    for (i = 0; i < 24; i++)
      send_request(i % 3 == 0 ? REQ_SET : REQ_GET, KEY_C ^ 32'(i % 4), HASH_TOP, rand_value());
  endtask

  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        rsp_ch.ready <= 1'b0;
        hold_cycles = hold_cycles - 1;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (expected_rsp.size() == 0) begin
        $error("response with no request outstanding");
        error_count++;
      end else begin
        want = expected_rsp.pop_front();
        if (rsp_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
          error_count++;
        end
        if (rsp_ch.is_new_key !== want.is_new_key) begin
          $error("is_new_key: expected %0d, got %0d", want.is_new_key, rsp_ch.is_new_key);
          error_count++;
        end
        if (rsp_ch.value_out !== want.value_out) begin
          $error("value_out: expected %h, got %h", want.value_out, rsp_ch.value_out);
          error_count++;
        end
      end
    end
  end

  initial begin
    int i;
    for (i = 0; i < SLOTS; i++) tbl_tag[i] = TAG_EMPTY;
    fill_count = '0;
    fill_limit = MAX_FILL_RST;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_wdata       <= '0;
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= REQ_SET;
    req_ch.key_id   <= '0;
    req_ch.key_hash <= '0;
    req_ch.value_in <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_fill_limit_extremes();
    test_basic_ops();
    test_tombstones();
    test_limit_present_keys();
    test_random_phase(560, 8'd72, 14, 61);
    test_backpressure();
    test_random_phase(560, 8'd192, 61, 14);
    test_random_phase(560, 8'd255, 0, 0);
    wait_idle(50);

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ open_addressing_hash_table_core.f @@
+incdir+sv
sv/oaht_pkg.sv
sv/oaht_if.sv
sv/oaht_hash_mod.sv
sv/oaht_slot_mem.sv
sv/oaht_ctrl.sv
sv/open_addressing_hash_table_core.sv
tb/testbench.sv
